[rtl/core/stack_with_delete_max_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stack with delete-max core.
// Both macros expect signals named clk and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_DELETE_MAX_CORE_MACROS_SVH
`define STACK_WITH_DELETE_MAX_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWDM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swdm_pkg.sv]
// ----------------------------------------------------------------------------
// swdm_pkg
// Sizes and codes shared by the stack with delete-max core and its channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swdm_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int OCC_W    = 7;
  localparam int STATUS_W = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_PUSH   = 2'd0;
  localparam kind_t KIND_CLEAR  = 2'd1;
  localparam kind_t KIND_DELMAX = 2'd2;
  localparam kind_t KIND_VIEW   = 2'd3;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

[rtl/core/swdm_in_if.sv]
// ----------------------------------------------------------------------------
// swdm_in_if
// Request channel of the stack core: operation kind and value to push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swdm_in_if;

  logic                               valid;
  logic                               ready;
  swdm_pkg::kind_t                    kind;
  logic signed [swdm_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);

endinterface

`default_nettype wire

[rtl/core/swdm_out_if.sv]
// ----------------------------------------------------------------------------
// swdm_out_if
// Result channel of the stack core: value, occupancy, status and last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swdm_out_if;

  logic                               valid;
  logic                               ready;
  logic signed [swdm_pkg::DATA_W-1:0] item_value;
  logic [swdm_pkg::OCC_W-1:0]         occupancy;
  swdm_pkg::status_t                  status;
  logic                               last;

  modport source (output valid, output item_value, output occupancy, output status,
                  output last, input ready);
  modport sink   (input valid, input item_value, input occupancy, input status,
                  input last, output ready);

endinterface

`default_nettype wire

[rtl/core/stack_with_delete_max_core.sv]
// ----------------------------------------------------------------------------
// stack_with_delete_max_core
// Bounded LIFO of signed words with push, clear, delete-all-maximum and view.
// ----------------------------------------------------------------------------
// Entries live in a single-port-write, single-port-read memory with a
// registered read, and a small sequencer walks it one entry per cycle
// during a delete-max pass. Push and clear are done as they are accepted,
// and the next request is taken straight after once their result is
// collected. Delete-max makes one pass over the memory to find the maximum,
// then a second pass that reads every entry again and writes back those
// that differ from it, packed towards the bottom, and then presents the
// result. View with N entries held gives N results, top first, each read
// and then presented, later if the result side stalls. The request side is
// not ready while a delete-max or view is in progress. A finished result
// sits in an output register, and a new request is taken no earlier than
// the cycle in which that result is collected. After reset the stack is
// empty and no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stack_with_delete_max_core_macros.svh"

module stack_with_delete_max_core (
  input  logic       clk,
  input  logic       rst_n,
  swdm_in_if.sink    in_chan,
  swdm_out_if.source out_chan
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_COMPACT = 3'd2;
  localparam logic [2:0] ST_DEL_OUT = 3'd3;
  localparam logic [2:0] ST_VIEW_RD = 3'd4;
  localparam logic [2:0] ST_VIEW_WT = 3'd5;

  localparam logic [swdm_pkg::CNT_W-1:0] CNT_FULL = swdm_pkg::CNT_W'(swdm_pkg::DEPTH);
  localparam logic [swdm_pkg::CNT_W-1:0] CNT_ONE  = swdm_pkg::CNT_W'(1);

  logic [2:0]                    state_r, state_nxt;
  logic [swdm_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [swdm_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic [swdm_pkg::CNT_W-1:0]    wr_r, wr_nxt;
  logic [swdm_pkg::DATA_W-1:0]   max_r, max_nxt;
  logic                          first_r, first_nxt;
  logic                          pend_r, pend_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [swdm_pkg::DATA_W-1:0]   out_value_r, out_value_nxt;
  logic [swdm_pkg::OCC_W-1:0]    out_occ_r, out_occ_nxt;
  swdm_pkg::status_t             out_status_r, out_status_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [swdm_pkg::DATA_W-1:0]   mem [swdm_pkg::DEPTH];
  logic [swdm_pkg::DATA_W-1:0]   rd_data_r;
  logic [swdm_pkg::IDX_W-1:0]    rd_addr;
  logic [swdm_pkg::CNT_W-1:0]    idx_dec;
  logic                          mem_we;
  logic [swdm_pkg::IDX_W-1:0]    mem_waddr;
  logic [swdm_pkg::DATA_W-1:0]   mem_wdata;

  logic                          out_free;
  logic                          in_ready;
  logic                          in_accept;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_accept = in_chan.valid && in_ready;

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.item_value = out_value_r;
  assign out_chan.occupancy  = out_occ_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.last       = out_last_r;

  // View walks downwards from the top, so it addresses one below the index.
  assign idx_dec = idx_r - CNT_ONE;
  assign rd_addr = ((state_r == ST_VIEW_RD) || (state_r == ST_VIEW_WT)) ?
                   idx_dec[swdm_pkg::IDX_W-1:0] : idx_r[swdm_pkg::IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    wr_nxt         = wr_r;
    max_nxt        = max_r;
    first_nxt      = first_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_value_nxt  = out_value_r;
    out_occ_nxt    = out_occ_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_occ_nxt    = swdm_pkg::OCC_W'(cnt_r);
          out_status_nxt = swdm_pkg::STATUS_OK;
          out_last_nxt   = 1'b1;
          case (in_chan.kind)
            swdm_pkg::KIND_PUSH: begin
              if (cnt_r == CNT_FULL) begin
                out_status_nxt = swdm_pkg::STATUS_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = cnt_r[swdm_pkg::IDX_W-1:0];
                mem_wdata   = in_chan.push_value;
                cnt_nxt     = cnt_r + CNT_ONE;
                out_occ_nxt = swdm_pkg::OCC_W'(cnt_r + CNT_ONE);
              end
            end
            swdm_pkg::KIND_CLEAR: begin
              cnt_nxt     = '0;
              out_occ_nxt = '0;
            end
            swdm_pkg::KIND_DELMAX: begin
              if (cnt_r == '0) begin
                out_status_nxt = swdm_pkg::STATUS_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SCAN;
                idx_nxt       = '0;
                first_nxt     = 1'b1;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                out_status_nxt = swdm_pkg::STATUS_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_VIEW_RD;
                idx_nxt       = cnt_r;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (idx_r != cnt_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + CNT_ONE;
        end
        if (pend_r) begin
          first_nxt = 1'b0;
          if (first_r || ($signed(rd_data_r) > $signed(max_r))) begin
            max_nxt = rd_data_r;
          end
        end
        if ((idx_r == cnt_r) && !pend_r) begin
          state_nxt = ST_COMPACT;
          idx_nxt   = '0;
          wr_nxt    = '0;
        end
      end

      ST_COMPACT: begin
        if (idx_r != cnt_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + CNT_ONE;
        end
        // The write pointer never passes the read pointer, so entries not yet
        // read are never overwritten.
        if (pend_r && (rd_data_r != max_r)) begin
          mem_we    = 1'b1;
          mem_waddr = wr_r[swdm_pkg::IDX_W-1:0];
          mem_wdata = rd_data_r;
          wr_nxt    = wr_r + CNT_ONE;
        end
        if ((idx_r == cnt_r) && !pend_r) begin
          state_nxt = ST_DEL_OUT;
          cnt_nxt   = wr_r;
        end
      end

      ST_DEL_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = max_r;
          out_occ_nxt    = swdm_pkg::OCC_W'(cnt_r);
          out_status_nxt = swdm_pkg::STATUS_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_VIEW_RD: begin
        state_nxt = ST_VIEW_WT;
      end

      ST_VIEW_WT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data_r;
          out_occ_nxt    = swdm_pkg::OCC_W'(cnt_r);
          out_status_nxt = swdm_pkg::STATUS_OK;
          out_last_nxt   = (idx_r == CNT_ONE);
          if (idx_r == CNT_ONE) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_dec;
            state_nxt = ST_VIEW_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      wr_r        <= '0;
      first_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      wr_r        <= wr_nxt;
      first_r     <= first_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    max_r        <= max_nxt;
    out_value_r  <= out_value_nxt;
    out_occ_r    <= out_occ_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  `SWDM_ASSERT_SAME(a_cnt_bounded, 1'b1, cnt_r <= CNT_FULL, "entry count beyond depth")
  `SWDM_ASSERT_SAME(a_ready_only_idle, in_ready, state_r == ST_IDLE, "ready while busy")
  `SWDM_ASSERT_SAME(a_compact_order, state_r == ST_COMPACT, wr_r <= idx_r,
                    "compaction write passed read")
  `SWDM_ASSERT_SAME(a_view_in_progress, out_valid_r && !out_last_r, state_r != ST_IDLE,
                    "non-final result outside a view")
  `SWDM_ASSERT_NEXT(a_push_grows, in_accept && (in_chan.kind == swdm_pkg::KIND_PUSH) &&
                    (cnt_r != CNT_FULL), cnt_r == $past(cnt_r) + CNT_ONE,
                    "push did not grow the stack")

endmodule

`default_nettype wire
